>>> hdl/first_fit_arena_allocator_assert.svh
// assertion macros for the arena allocator
// needs i_clk and i_rst_n in the scope of each use
`ifndef FIRST_FIT_ARENA_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffa check failed");

// next-cycle implication
`define FFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffa check failed");

`endif

>>> hdl/ffa_pkg.sv
// types, constants and codes for the arena allocator
// no dependencies
package ffa_pkg;

    localparam int ARENA_MAX_BYTES = 65536;
    localparam int HEADER_BYTES    = 32;
    localparam int PAGE_BYTES      = 4096;
    localparam int MAX_CHUNKS      = 64;

    localparam int IDX_W  = $clog2(MAX_CHUNKS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int ADDR_W = 16;
    localparam int SIZE_W = 17;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_INIT    = 2'd2;
    localparam logic [1:0] CMD_DESTROY = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNINIT  = 3'd1;
    localparam logic [2:0] ST_NOMEM   = 3'd2;
    localparam logic [2:0] ST_BADSIZE = 3'd3;
    localparam logic [2:0] ST_ALREADY = 3'd4;
    localparam logic [2:0] ST_BADOFF  = 3'd5;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] bytes;
        logic              used;
    } t_entry;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_INIT,
        CM_MARK,
        CM_SPLIT,
        CM_DROP1,
        CM_DROP2
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode        mode;
        logic [IDX_W-1:0]  pos;
        t_entry            wa;
        t_entry            wb;
        logic [CNT_W-1:0]  count;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] off;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_UPD,
        S_OUT
    } t_state;

endpackage

>>> hdl/ffa_req_if.sv
// request channel: valid, ready and request beat
// depends on ffa_pkg
interface ffa_req_if import ffa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] payload_offset;

    modport source (output valid, cmd, req_size, payload_offset, input ready);
    modport sink   (input valid, cmd, req_size, payload_offset, output ready);
endinterface

>>> hdl/ffa_rsp_if.sv
// response channel: valid, ready and response beat
// depends on ffa_pkg
interface ffa_rsp_if import ffa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [SIZE_W-1:0] result_value;

    modport source (output valid, status, result_value, input ready);
    modport sink   (input valid, status, result_value, output ready);
endinterface

>>> hdl/first_fit_arena_allocator.sv
// top level: row of chunk cells, first-fit select and command sequencer
// depends on ffa_pkg, ffa_req_if, ffa_rsp_if, ffa_cell, assertion macros
//
//  channel  dir  beat
//  i_req    in   cmd, req_size, payload_offset
//  o_rsp    out  status, result_value
//
// each request goes through accept, parallel compare and first-one select
// over the cells, a shift/update step of the cell row, and response load.
// a new request is taken once the response register has the result.
// synchronous active-low reset clears the arena flag and chunk count;
// cell contents are only read below the count. a stalled response holds
// the sequencer in its last state.
`include "first_fit_arena_allocator_assert.svh"

module first_fit_arena_allocator import ffa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ffa_req_if.sink   i_req,
    ffa_rsp_if.source o_rsp
);
    t_state            r_state, n_state;
    logic              r_ready, n_ready;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [1:0]        r_cmd;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_off;
    logic              r_found;
    logic [IDX_W-1:0]  r_pos;
    t_entry            r_cur, r_prev, r_next;
    logic [2:0]        r_status, n_status;
    logic [SIZE_W-1:0] r_value, n_value;
    logic              r_ovalid;
    logic [2:0]        r_ostatus;
    logic [SIZE_W-1:0] r_ovalue;

    t_cell_ctl             w_ctl;
    t_entry                w_ent [MAX_CHUNKS];
    logic [MAX_CHUNKS-1:0] w_fit, w_hit, w_vec, w_oh;
    logic [IDX_W-1:0]      w_idx;
    t_entry                w_cur, w_prev, w_next;
    logic                  w_out_free;

    genvar g;
    generate
        for (g = 0; g < MAX_CHUNKS; g++) begin : g_cell
            t_entry w_l, w_r1, w_r2;
            if (g == 0) begin : g_l0
                assign w_l = '0;
            end else begin : g_l
                assign w_l = w_ent[g-1];
            end
            if (g + 1 < MAX_CHUNKS) begin : g_r1
                assign w_r1 = w_ent[g+1];
            end else begin : g_r1z
                assign w_r1 = '0;
            end
            if (g + 2 < MAX_CHUNKS) begin : g_r2
                assign w_r2 = w_ent[g+2];
            end else begin : g_r2z
                assign w_r2 = '0;
            end
            ffa_cell u_cell (
                .i_clk    (i_clk),
                .i_idx    (IDX_W'(g)),
                .i_ctl    (w_ctl),
                .i_left   (w_l),
                .i_right1 (w_r1),
                .i_right2 (w_r2),
                .o_entry  (w_ent[g]),
                .o_fit    (w_fit[g]),
                .o_hit    (w_hit[g])
            );
        end
    endgenerate

    // first-one select
    assign w_vec = (r_cmd == CMD_ALLOC) ? w_fit : w_hit;
    assign w_oh  = w_vec & (~w_vec + MAX_CHUNKS'(1));

    always_comb begin
        w_idx  = '0;
        w_cur  = '0;
        w_prev = '0;
        w_next = '0;
        for (int j = 0; j < MAX_CHUNKS; j++) begin
            if (w_oh[j]) begin
                w_idx = w_idx | IDX_W'(j);
                w_cur = w_cur | w_ent[j];
            end
            if (j + 1 < MAX_CHUNKS) begin
                if (w_oh[j+1]) w_prev = w_prev | w_ent[j];
            end
            if (j > 0) begin
                if (w_oh[j-1]) w_next = w_next | w_ent[j];
            end
        end
    end

    assign w_out_free = !r_ovalid || o_rsp.ready;

    // command decision
    logic [SIZE_W:0]   w_rnd;
    logic [SIZE_W:0]   w_split_lim;
    logic              w_has_next, w_next_free, w_prev_free;
    logic [ADDR_W-1:0] w_sz16;

    assign w_sz16      = r_size[ADDR_W-1:0];
    assign w_rnd       = ({1'b0, r_size} + (SIZE_W+1)'(PAGE_BYTES - 1)) &
                         ~(SIZE_W+1)'(PAGE_BYTES - 1);
    assign w_split_lim = {1'b0, r_size} + (SIZE_W+1)'(HEADER_BYTES);
    assign w_has_next  = ({1'b0, r_pos} + CNT_W'(1)) < r_count;
    assign w_next_free = w_has_next && !r_next.used;
    assign w_prev_free = (r_pos != '0) && !r_prev.used;

    always_comb begin
        w_ctl       = '0;
        w_ctl.mode  = CM_HOLD;
        w_ctl.count = r_count;
        w_ctl.size  = r_size;
        w_ctl.off   = r_off;
        w_ctl.pos   = r_pos;
        n_ready     = r_ready;
        n_count     = r_count;
        n_status    = ST_OK;
        n_value     = '0;
        if (r_state == S_UPD) begin
            unique case (r_cmd)
                CMD_ALLOC: begin
                    if (!r_ready) n_status = ST_UNINIT;
                    else if (!r_found) n_status = ST_NOMEM;
                    else begin
                        n_value = {1'b0, r_cur.start} + SIZE_W'(HEADER_BYTES);
                        if (({2'b0, r_cur.bytes} > w_split_lim) &&
                            (r_count < CNT_W'(MAX_CHUNKS))) begin
                            w_ctl.mode     = CM_SPLIT;
                            w_ctl.wa       = '{start: r_cur.start, bytes: w_sz16, used: 1'b1};
                            w_ctl.wb.start = r_cur.start + ADDR_W'(HEADER_BYTES) + w_sz16;
                            w_ctl.wb.bytes = r_cur.bytes - w_sz16 - ADDR_W'(HEADER_BYTES);
                            w_ctl.wb.used  = 1'b0;
                            n_count        = r_count + CNT_W'(1);
                        end else begin
                            w_ctl.mode = CM_MARK;
                            w_ctl.wa   = '{start: r_cur.start, bytes: r_cur.bytes, used: 1'b1};
                        end
                    end
                end
                CMD_FREE: begin
                    if (!r_ready) n_status = ST_UNINIT;
                    else if (!r_found) n_status = ST_BADOFF;
                    else if (!r_cur.used) n_status = ST_ALREADY;
                    else begin
                        priority if (w_next_free && w_prev_free) begin
                            w_ctl.mode     = CM_DROP2;
                            w_ctl.pos      = r_pos - IDX_W'(1);
                            w_ctl.wa.start = r_prev.start;
                            w_ctl.wa.bytes = r_prev.bytes + r_cur.bytes + r_next.bytes +
                                             ADDR_W'(2 * HEADER_BYTES);
                            w_ctl.wa.used  = 1'b0;
                            n_count        = r_count - CNT_W'(2);
                        end else if (w_next_free) begin
                            w_ctl.mode     = CM_DROP1;
                            w_ctl.wa.start = r_cur.start;
                            w_ctl.wa.bytes = r_cur.bytes + r_next.bytes +
                                             ADDR_W'(HEADER_BYTES);
                            w_ctl.wa.used  = 1'b0;
                            n_count        = r_count - CNT_W'(1);
                        end else if (w_prev_free) begin
                            w_ctl.mode     = CM_DROP1;
                            w_ctl.pos      = r_pos - IDX_W'(1);
                            w_ctl.wa.start = r_prev.start;
                            w_ctl.wa.bytes = r_prev.bytes + r_cur.bytes +
                                             ADDR_W'(HEADER_BYTES);
                            w_ctl.wa.used  = 1'b0;
                            n_count        = r_count - CNT_W'(1);
                        end else begin
                            w_ctl.mode = CM_MARK;
                            w_ctl.wa   = '{start: r_cur.start, bytes: r_cur.bytes, used: 1'b0};
                        end
                    end
                end
                CMD_INIT: begin
                    if ((r_size > SIZE_W'(ARENA_MAX_BYTES)) || (w_rnd == '0) ||
                        (w_rnd > (SIZE_W+1)'(ARENA_MAX_BYTES)) ||
                        (w_rnd <= (SIZE_W+1)'(HEADER_BYTES))) begin
                        n_status = ST_BADSIZE;
                    end else begin
                        w_ctl.mode     = CM_INIT;
                        w_ctl.wa.start = '0;
                        w_ctl.wa.bytes = ADDR_W'(w_rnd - (SIZE_W+1)'(HEADER_BYTES));
                        w_ctl.wa.used  = 1'b0;
                        n_ready        = 1'b1;
                        n_count        = CNT_W'(1);
                        n_value        = w_rnd[SIZE_W-1:0];
                    end
                end
                CMD_DESTROY: begin
                    if (!r_ready) n_status = ST_UNINIT;
                    else begin
                        n_ready = 1'b0;
                        n_count = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_EVAL;
            S_EVAL: n_state = S_UPD;
            S_UPD:  n_state = S_OUT;
            S_OUT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ready  <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_count <= n_count;
            if (r_state == S_OUT && w_out_free) r_ovalid <= 1'b1;
            else if (o_rsp.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_cmd  <= i_req.cmd;
            r_size <= i_req.req_size;
            r_off  <= i_req.payload_offset;
        end
        if (r_state == S_EVAL) begin
            r_found <= |w_vec;
            r_pos   <= w_idx;
            r_cur   <= w_cur;
            r_prev  <= w_prev;
            r_next  <= w_next;
        end
        if (r_state == S_UPD) begin
            r_status <= n_status;
            r_value  <= n_value;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_ostatus <= r_status;
            r_ovalue  <= r_value;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_ostatus;
    assign o_rsp.result_value = r_ovalue;

    `FFA_ASSERT_NOW(a_count_max, 1'b1, r_count <= CNT_W'(MAX_CHUNKS))
    `FFA_ASSERT_NOW(a_unready_empty, !r_ready, r_count == '0)
    `FFA_ASSERT_NOW(a_first_onehot, 1'b1, $onehot0(w_oh))
    `FFA_ASSERT_NEXT(a_out_load, r_state == S_OUT && w_out_free, r_ovalid)
endmodule

>>> hdl/ffa_cell.sv
// one table cell: holds a chunk entry, compares it, shifts with neighbors
// depends on ffa_pkg
module ffa_cell import ffa_pkg::*; (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cell_ctl        i_ctl,
    input  t_entry           i_left,
    input  t_entry           i_right1,
    input  t_entry           i_right2,
    output t_entry           o_entry,
    output logic             o_fit,
    output logic             o_hit
);
    t_entry           r_entry;
    t_entry           n_entry;
    logic [CNT_W-1:0] w_idx;
    logic [CNT_W-1:0] w_pos;
    logic [CNT_W-1:0] w_pos1;
    logic             w_valid;

    assign w_idx   = {1'b0, i_idx};
    assign w_pos   = {1'b0, i_ctl.pos};
    assign w_pos1  = w_pos + CNT_W'(1);
    assign w_valid = w_idx < i_ctl.count;
    assign o_fit   = w_valid && !r_entry.used && ({1'b0, r_entry.bytes} >= i_ctl.size);
    assign o_hit   = w_valid &&
                     (({1'b0, r_entry.start} + SIZE_W'(HEADER_BYTES)) == {1'b0, i_ctl.off});
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.mode)
            CM_HOLD: ;
            CM_INIT: begin
                if (w_idx == '0) n_entry = i_ctl.wa;
            end
            CM_MARK: begin
                if (w_idx == w_pos) n_entry = i_ctl.wa;
            end
            CM_SPLIT: begin
                if (w_idx == w_pos) n_entry = i_ctl.wa;
                else if (w_idx == w_pos1) n_entry = i_ctl.wb;
                else if (w_idx > w_pos1) n_entry = i_left;
            end
            CM_DROP1: begin
                if (w_idx == w_pos) n_entry = i_ctl.wa;
                else if (w_idx > w_pos) n_entry = i_right1;
            end
            CM_DROP2: begin
                if (w_idx == w_pos) n_entry = i_ctl.wa;
                else if (w_idx > w_pos) n_entry = i_right2;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end
endmodule
